// ----- rtl/polar_vector_alu_assert.svh -----
// Assertion macros used by the polar vector ALU top level.
`ifndef POLAR_VECTOR_ALU_ASSERT_SVH
`define POLAR_VECTOR_ALU_ASSERT_SVH

// General property, sampled on the rising clock and quiet during reset.
`define PVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication from a condition to a consequence.
`define PVA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/pva_pkg.sv -----
package pva_pkg;

  // Default configuration.
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF     = 16;
  localparam int unsigned MAX_STAGES        = 24;
  localparam int unsigned GUARD_BITS        = 8;

  // Field and datapath widths.
  localparam int unsigned MAG_W = 32;
  localparam int unsigned DIR_W = 16;
  localparam int unsigned DOT_W = 64;
  localparam int unsigned ANG_W = 32;
  localparam int unsigned ROT_W = 42;
  localparam int unsigned VEC_W = 44;

  // Inverse CORDIC gain as a Q0.32 fraction.
  localparam logic [31:0] INV_GAIN     = 32'd2608131496;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // atan(2^-i) with 2^32 units per turn.
  localparam logic [31:0] ATAN_TURN [MAX_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Operation codes.
  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_DOT = 3'd2,
    KIND_MUL = 3'd3,
    KIND_DIV = 3'd4
  } kind_e;

  // Result of the scale divider.
  typedef struct packed {
    logic signed [MAG_W-1:0] mag;
    logic                    ov;
    logic                    dz;
  } div_res_t;

endpackage

// ----- rtl/pva_if.sv -----
// Request channel: one operation with two polar vectors and a scalar.
interface pva_req_if import pva_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [2:0]              kind;
  logic signed [MAG_W-1:0] magnitude_a;
  logic signed [DIR_W-1:0] direction_a;
  logic signed [MAG_W-1:0] magnitude_b;
  logic signed [DIR_W-1:0] direction_b;
  logic signed [MAG_W-1:0] scale;

  modport source (output valid, kind, magnitude_a, direction_a, magnitude_b, direction_b,
                  scale, input ready);
  modport sink (input valid, kind, magnitude_a, direction_a, magnitude_b, direction_b,
                scale, output ready);
endinterface

// Response channel: one result item per request.
interface pva_rsp_if import pva_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [MAG_W-1:0] result_magnitude;
  logic signed [DIR_W-1:0] result_direction;
  logic signed [DOT_W-1:0] dot_value;
  logic                    overflow;
  logic                    divide_by_zero;

  modport source (output valid, result_magnitude, result_direction, dot_value, overflow,
                  divide_by_zero, input ready);
  modport sink (input valid, result_magnitude, result_direction, dot_value, overflow,
                divide_by_zero, output ready);
endinterface

// ----- rtl/pva_cordic.sv -----
// Pipelined CORDIC, one micro-rotation per stage, followed by two stages
// that remove the CORDIC gain.
module pva_cordic import pva_pkg::*; #(
  parameter int unsigned W      = ROT_W,
  parameter int unsigned STAGES = CORDIC_STAGES_DEF,
  parameter bit          VECTOR = 1'b0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [W-1:0]  x_i,
  input  logic signed [W-1:0]  y_i,
  input  logic [ANG_W-1:0]     z_i,
  output logic signed [W-1:0]  x_o,
  output logic signed [W-1:0]  y_o,
  output logic [ANG_W-1:0]     z_o
);

  localparam int unsigned HI_W = W - ANG_W;
  localparam int unsigned HP_W = HI_W + 32;

  logic signed [W-1:0] x_s [STAGES+1];
  logic signed [W-1:0] y_s [STAGES+1];
  logic [ANG_W-1:0]    z_s [STAGES+1];

  assign x_s[0] = x_i;
  assign y_s[0] = y_i;
  assign z_s[0] = z_i;

  // Micro-rotation stages.
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [W-1:0] xs, ys;
    logic                ccw;
    logic signed [W-1:0] x_q, y_q;
    logic [ANG_W-1:0]    z_q;

    assign xs  = x_s[i] >>> i;
    assign ys  = y_s[i] >>> i;
    // Rotation mode drives z toward zero, vectoring mode drives y toward zero.
    assign ccw = VECTOR ? y_s[i][W-1] : ~z_s[i][ANG_W-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (ccw) begin
          x_q <= x_s[i] - ys;
          y_q <= y_s[i] + xs;
          z_q <= z_s[i] - ATAN_TURN[i];
        end else begin
          x_q <= x_s[i] + ys;
          y_q <= y_s[i] - xs;
          z_q <= z_s[i] + ATAN_TURN[i];
        end
      end
    end

    assign x_s[i+1] = x_q;
    assign y_s[i+1] = y_q;
    assign z_s[i+1] = z_q;
  end

  // Gain removal, first half: split magnitudes and multiply.
  logic [W-1:0]     xm, ym;
  logic             xneg_q, yneg_q;
  logic [HP_W-1:0]  xhi_q, yhi_q;
  logic [63:0]      xlo_q, ylo_q;
  logic [ANG_W-1:0] zg_q;

  assign xm = x_s[STAGES][W-1] ? W'(-x_s[STAGES]) : W'(x_s[STAGES]);
  assign ym = y_s[STAGES][W-1] ? W'(-y_s[STAGES]) : W'(y_s[STAGES]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xneg_q <= x_s[STAGES][W-1];
      yneg_q <= y_s[STAGES][W-1];
      xhi_q  <= HP_W'(xm[W-1:ANG_W]) * HP_W'(INV_GAIN);
      yhi_q  <= HP_W'(ym[W-1:ANG_W]) * HP_W'(INV_GAIN);
      xlo_q  <= 64'(xm[ANG_W-1:0]) * 64'(INV_GAIN);
      ylo_q  <= 64'(ym[ANG_W-1:0]) * 64'(INV_GAIN);
      zg_q   <= z_s[STAGES];
    end
  end

  // Gain removal, second half: combine partial products, restore the sign.
  logic [HP_W-1:0]     xr, yr;
  logic signed [W-1:0] x_q, y_q;
  logic [ANG_W-1:0]    z_q;

  assign xr = xhi_q + HP_W'(xlo_q[63:32]);
  assign yr = yhi_q + HP_W'(ylo_q[63:32]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= xneg_q ? -$signed(W'(xr)) : $signed(W'(xr));
      y_q <= yneg_q ? -$signed(W'(yr)) : $signed(W'(yr));
      z_q <= zg_q;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// ----- rtl/pva_div.sv -----
// Pipelined restoring divider for the scale divide, STEPS quotient bits per
// stage. It registers operand preparation, the quotient stages, then sign
// and saturation.
module pva_div import pva_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned STEPS     = 2,
  parameter int unsigned STAGES    = 24
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [MAG_W-1:0] dividend_i,
  input  logic signed [MAG_W-1:0] divisor_i,
  output div_res_t                res_o
);

  localparam int unsigned DP = STEPS * STAGES;
  localparam int unsigned RW = MAG_W + 1;

  typedef struct packed {
    logic neg;
    logic zero;
    logic a_pos;
    logic a_neg;
  } ctl_t;

  logic [RW-1:0]    rem_s [STAGES+1];
  logic [DP-1:0]    dvd_s [STAGES+1];
  logic [DP-1:0]    quo_s [STAGES+1];
  logic [MAG_W-1:0] dsr_s [STAGES+1];
  ctl_t             ctl_s [STAGES+1];

  // Operand preparation: magnitudes, signs and the zero divisor case.
  logic [MAG_W-1:0] a_abs, b_abs;
  logic [DP-1:0]    dvd0_q;
  logic [MAG_W-1:0] dsr0_q;
  ctl_t             ctl0_q;

  assign a_abs = dividend_i[MAG_W-1] ? MAG_W'(-dividend_i) : MAG_W'(dividend_i);
  assign b_abs = divisor_i[MAG_W-1] ? MAG_W'(-divisor_i) : MAG_W'(divisor_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvd0_q       <= DP'(a_abs) << FRAC_BITS;
      dsr0_q       <= b_abs;
      ctl0_q.neg   <= dividend_i[MAG_W-1] ^ divisor_i[MAG_W-1];
      ctl0_q.zero  <= (divisor_i == '0);
      ctl0_q.a_pos <= ~dividend_i[MAG_W-1] && (dividend_i != '0);
      ctl0_q.a_neg <= dividend_i[MAG_W-1];
    end
  end

  assign rem_s[0] = '0;
  assign dvd_s[0] = dvd0_q;
  assign quo_s[0] = '0;
  assign dsr_s[0] = dsr0_q;
  assign ctl_s[0] = ctl0_q;

  // Quotient stages.
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic [RW-1:0]    r;
    logic [DP-1:0]    dv, q;
    logic [RW-1:0]    rem_q;
    logic [DP-1:0]    dvd_q, quo_q;
    logic [MAG_W-1:0] dsr_q;
    ctl_t             ctl_q;

    always_comb begin
      r  = rem_s[i];
      dv = dvd_s[i];
      q  = quo_s[i];
      for (int k = 0; k < STEPS; k++) begin
        r  = {r[RW-2:0], dv[DP-1]};
        dv = {dv[DP-2:0], 1'b0};
        if (r >= {1'b0, dsr_s[i]}) begin
          r = r - {1'b0, dsr_s[i]};
          q = {q[DP-2:0], 1'b1};
        end else begin
          q = {q[DP-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= r;
        dvd_q <= dv;
        quo_q <= q;
        dsr_q <= dsr_s[i];
        ctl_q <= ctl_s[i];
      end
    end

    assign rem_s[i+1] = rem_q;
    assign dvd_s[i+1] = dvd_q;
    assign quo_s[i+1] = quo_q;
    assign dsr_s[i+1] = dsr_q;
    assign ctl_s[i+1] = ctl_q;
  end

  // Sign, saturation and the zero divisor result.
  logic [DP-1:0] q_fin;
  ctl_t          c_fin;
  logic          big_pos, big_neg;
  div_res_t      res_d, res_q;

  assign q_fin   = quo_s[STAGES];
  assign c_fin   = ctl_s[STAGES];
  assign big_pos = |q_fin[DP-1:MAG_W-1];
  assign big_neg = (|q_fin[DP-1:MAG_W]) || (q_fin[MAG_W-1] && (|q_fin[MAG_W-2:0]));

  always_comb begin
    res_d.dz  = 1'b0;
    res_d.ov  = 1'b0;
    res_d.mag = '0;
    if (c_fin.zero) begin
      res_d.dz = 1'b1;
      res_d.ov = c_fin.a_pos || c_fin.a_neg;
      if (c_fin.a_pos) begin
        res_d.mag = {1'b0, {(MAG_W-1){1'b1}}};
      end else if (c_fin.a_neg) begin
        res_d.mag = {1'b1, {(MAG_W-1){1'b0}}};
      end
    end else if (c_fin.neg) begin
      if (big_neg) begin
        res_d.ov  = 1'b1;
        res_d.mag = {1'b1, {(MAG_W-1){1'b0}}};
      end else begin
        res_d.mag = -$signed(q_fin[MAG_W-1:0]);
      end
    end else begin
      if (big_pos) begin
        res_d.ov  = 1'b1;
        res_d.mag = {1'b0, {(MAG_W-1){1'b1}}};
      end else begin
        res_d.mag = $signed(q_fin[MAG_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- rtl/polar_vector_alu.sv -----
// Polar vector ALU.
// One request item on req_i carries an operation kind, two vectors in polar
// form (signed Q16.16 magnitude, 16-bit binary angle) and a Q16.16 scale.
// Each request gives exactly one result item on rsp_o: magnitude, angle,
// Q32.32 dot product and the overflow and divide-by-zero flags.
// Add and subtract go through a rotation CORDIC for both vectors, a vector
// sum and a vectoring CORDIC; the dot product shares the rotation CORDICs;
// scale divide runs in a pipelined restoring divider beside them.
// The path from acceptance to a valid result runs through the two
// CORDIC pipelines in series, and the other paths are delayed to match.
// One item is accepted per cycle while results are taken.
// Reset clears only the stage valid bits; the pipeline is empty afterward
// and ready is high. When the receiver holds ready low with a result
// waiting, the whole pipeline freezes and req_i.ready drops until the
// result is taken; nothing is lost or repeated.
`include "polar_vector_alu_assert.svh"

module polar_vector_alu import pva_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int unsigned FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pva_req_if.sink      req_i,
  pva_rsp_if.source    rsp_o
);

  localparam int unsigned N          = CORDIC_STAGES;
  localparam int unsigned LAT        = 2 * N + 8;
  localparam int unsigned DQ         = MAG_W + FRAC_BITS;
  localparam int unsigned DIV_BUDGET = 2 * N + 3;
  localparam int unsigned DIV_STEPS  = (DQ + DIV_BUDGET - 1) / DIV_BUDGET;
  localparam int unsigned DIV_STAGES = (DQ + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned DIV_PAD    = LAT - 4 - DIV_STAGES;
  localparam int unsigned SIDE_PAD   = LAT - 4;
  localparam int unsigned DOT_PAD    = N + 1;
  localparam int unsigned ZERO_PAD   = N + 2;

  localparam logic signed [ROT_W-1:0] RND_R = ROT_W'(1) << (GUARD_BITS - 1);
  localparam logic signed [ROT_W-1:0] LIM_R = ROT_W'(1) << (MAG_W - 1);
  localparam logic signed [VEC_W-1:0] RND_V = VEC_W'(1) << (GUARD_BITS - 1);
  localparam logic [ANG_W-1:0]        ANG_RND = 32'h0000_8000;
  localparam logic signed [MAG_W-1:0] MAG_MAX = {1'b0, {(MAG_W-1){1'b1}}};
  localparam logic signed [MAG_W-1:0] MAG_MIN = {1'b1, {(MAG_W-1){1'b0}}};
  localparam logic signed [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
  localparam logic signed [DOT_W-1:0] DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};

  typedef struct packed {
    logic [2:0]              kind;
    logic [DIR_W-1:0]        dir;
    logic signed [MAG_W-1:0] mag;
    logic                    ov;
  } side_t;

  // Pipeline control: every stage advances together.
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en          = ~vld_q[LAT-1] || rsp_o.ready;
  assign req_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], req_i.valid};
    end
  end

  // Input stage: operands and the half-plane prerotation for both vectors.
  logic [ANG_W-1:0]        za_in, zb_in;
  logic signed [ROT_W-1:0] xa_in, xb_in;
  logic [2:0]              kind_q;
  logic [DIR_W-1:0]        dira_q;
  logic signed [MAG_W-1:0] ma_q, sc_q;
  logic signed [ROT_W-1:0] xa_q, xb_q;
  logic [ANG_W-1:0]        za_q, zb_q;

  assign za_in = {req_i.direction_a, 16'h0000};
  assign zb_in = {req_i.direction_b, 16'h0000} + ((req_i.kind == KIND_SUB) ? HALF_TURN : '0);
  assign xa_in = ROT_W'(req_i.magnitude_a) <<< GUARD_BITS;
  assign xb_in = ROT_W'(req_i.magnitude_b) <<< GUARD_BITS;

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_q <= req_i.kind;
      dira_q <= req_i.direction_a;
      ma_q   <= req_i.magnitude_a;
      sc_q   <= req_i.scale;
      if (((za_in + QUARTER_TURN) & HALF_TURN) != '0) begin
        xa_q <= -xa_in;
        za_q <= za_in + HALF_TURN;
      end else begin
        xa_q <= xa_in;
        za_q <= za_in;
      end
      if (((zb_in + QUARTER_TURN) & HALF_TURN) != '0) begin
        xb_q <= -xb_in;
        zb_q <= zb_in + HALF_TURN;
      end else begin
        xb_q <= xb_in;
        zb_q <= zb_in;
      end
    end
  end

  // Polar to x,y for both vectors.
  logic signed [ROT_W-1:0] ax, ay, bx, by;

  pva_cordic #(.W(ROT_W), .STAGES(N), .VECTOR(1'b0)) u_rot_a (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (xa_q),
    .y_i   ('0),
    .z_i   (za_q),
    .x_o   (ax),
    .y_o   (ay),
    .z_o   ()
  );

  pva_cordic #(.W(ROT_W), .STAGES(N), .VECTOR(1'b0)) u_rot_b (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (xb_q),
    .y_i   ('0),
    .z_i   (zb_q),
    .x_o   (bx),
    .y_o   (by),
    .z_o   ()
  );

  // Vector sum, and rounded, clamped components for the dot product.
  logic signed [ROT_W-1:0] gax, gay, gbx, gby;
  logic signed [VEC_W-1:0] sx_q, sy_q;
  logic signed [MAG_W:0]   cax_q, cay_q, cbx_q, cby_q;

  assign gax = (ax + RND_R) >>> GUARD_BITS;
  assign gay = (ay + RND_R) >>> GUARD_BITS;
  assign gbx = (bx + RND_R) >>> GUARD_BITS;
  assign gby = (by + RND_R) >>> GUARD_BITS;

  function automatic logic signed [MAG_W:0] clamp_c(input logic signed [ROT_W-1:0] v);
    if (v > LIM_R) begin
      return (MAG_W+1)'(LIM_R);
    end else if (v < -LIM_R) begin
      return (MAG_W+1)'(-LIM_R);
    end
    return (MAG_W+1)'(v);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q  <= VEC_W'(ax) + VEC_W'(bx);
      sy_q  <= VEC_W'(ay) + VEC_W'(by);
      cax_q <= clamp_c(gax);
      cay_q <= clamp_c(gay);
      cbx_q <= clamp_c(gbx);
      cby_q <= clamp_c(gby);
    end
  end

  // Dot products, and vectoring prerotation into the right half plane.
  logic signed [2*MAG_W+1:0] p1_q, p2_q;
  logic signed [VEC_W-1:0]   vx_q, vy_q;
  logic [ANG_W-1:0]          vz_q;
  logic                      vzero_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q    <= cax_q * cbx_q;
      p2_q    <= cay_q * cby_q;
      vzero_q <= (sx_q == '0) && (sy_q == '0);
      if (sx_q[VEC_W-1]) begin
        vx_q <= -sx_q;
        vy_q <= -sy_q;
        vz_q <= HALF_TURN;
      end else begin
        vx_q <= sx_q;
        vy_q <= sy_q;
        vz_q <= '0;
      end
    end
  end

  // Dot product sum with saturation to 64 bits.
  logic signed [2*MAG_W+2:0] dsum;
  logic signed [DOT_W-1:0]   dot_q;
  logic                      dov_q;

  assign dsum = (2*MAG_W+3)'(p1_q) + (2*MAG_W+3)'(p2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dov_q <= (dsum[2*MAG_W+2:DOT_W-1] != '0) && (dsum[2*MAG_W+2:DOT_W-1] != '1);
      if (!dsum[2*MAG_W+2] && (dsum[2*MAG_W+2:DOT_W-1] != '0)) begin
        dot_q <= DOT_MAX;
      end else if (dsum[2*MAG_W+2] && (dsum[2*MAG_W+2:DOT_W-1] != '1)) begin
        dot_q <= DOT_MIN;
      end else begin
        dot_q <= DOT_W'(dsum);
      end
    end
  end

  // x,y back to magnitude and angle.
  logic signed [VEC_W-1:0] vmx;
  logic [ANG_W-1:0]        vmz;

  pva_cordic #(.W(VEC_W), .STAGES(N), .VECTOR(1'b1)) u_vec (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (vx_q),
    .y_i   (vy_q),
    .z_i   (vz_q),
    .x_o   (vmx),
    .y_o   (),
    .z_o   (vmz)
  );

  // Scale multiply beside the CORDIC path.
  logic [2:0]              kind2_q;
  logic [DIR_W-1:0]        dir2_q;
  logic signed [2*MAG_W-1:0] prod_q, prod_sh;
  side_t                   side3_q;

  assign prod_sh = prod_q >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind2_q      <= kind_q;
      dir2_q       <= dira_q;
      prod_q       <= ma_q * sc_q;
      side3_q.kind <= kind2_q;
      side3_q.dir  <= dir2_q;
      side3_q.ov   <= (prod_sh[2*MAG_W-1:MAG_W-1] != '0) &&
                      (prod_sh[2*MAG_W-1:MAG_W-1] != '1);
      if (!prod_sh[2*MAG_W-1] && (prod_sh[2*MAG_W-1:MAG_W-1] != '0)) begin
        side3_q.mag <= MAG_MAX;
      end else if (prod_sh[2*MAG_W-1] && (prod_sh[2*MAG_W-1:MAG_W-1] != '1)) begin
        side3_q.mag <= MAG_MIN;
      end else begin
        side3_q.mag <= MAG_W'(prod_sh);
      end
    end
  end

  // Scale divide.
  div_res_t dres;

  pva_div #(.FRAC_BITS(FRAC_BITS), .STEPS(DIV_STEPS), .STAGES(DIV_STAGES)) u_div (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (ma_q),
    .divisor_i  (sc_q),
    .res_o      (dres)
  );

  // Delay lines that line every path up with the vectoring output.
  side_t                   side_dly_q [SIDE_PAD];
  div_res_t                div_dly_q  [DIV_PAD];
  logic signed [DOT_W-1:0] dot_dly_q  [DOT_PAD];
  logic                    dov_dly_q  [DOT_PAD];
  logic                    zero_dly_q [ZERO_PAD];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_dly_q[0] <= side3_q;
      for (int k = 1; k < SIDE_PAD; k++) begin
        side_dly_q[k] <= side_dly_q[k-1];
      end
      div_dly_q[0] <= dres;
      for (int k = 1; k < DIV_PAD; k++) begin
        div_dly_q[k] <= div_dly_q[k-1];
      end
      dot_dly_q[0] <= dot_q;
      dov_dly_q[0] <= dov_q;
      for (int k = 1; k < DOT_PAD; k++) begin
        dot_dly_q[k] <= dot_dly_q[k-1];
        dov_dly_q[k] <= dov_dly_q[k-1];
      end
      zero_dly_q[0] <= vzero_q;
      for (int k = 1; k < ZERO_PAD; k++) begin
        zero_dly_q[k] <= zero_dly_q[k-1];
      end
    end
  end

  // Final rounding, saturation and selection by operation.
  side_t                   side_f;
  div_res_t                div_f;
  logic signed [VEC_W-1:0] vm_pos, vm_rnd;
  logic [ANG_W-1:0]        ang_rnd;
  logic signed [MAG_W-1:0] rmag_d, rmag_q;
  logic [DIR_W-1:0]        rdir_d, rdir_q;
  logic signed [DOT_W-1:0] rdot_d, rdot_q;
  logic                    rov_d, rov_q, rdz_d, rdz_q;

  assign side_f  = side_dly_q[SIDE_PAD-1];
  assign div_f   = div_dly_q[DIV_PAD-1];
  assign vm_pos  = vmx[VEC_W-1] ? '0 : vmx;
  assign vm_rnd  = (vm_pos + RND_V) >>> GUARD_BITS;
  assign ang_rnd = vmz + ANG_RND;

  always_comb begin
    rmag_d = '0;
    rdir_d = '0;
    rdot_d = '0;
    rov_d  = 1'b0;
    rdz_d  = 1'b0;
    case (side_f.kind)
      KIND_ADD, KIND_SUB: begin
        if (vm_rnd[VEC_W-1:MAG_W-1] != '0) begin
          rmag_d = MAG_MAX;
          rov_d  = 1'b1;
        end else begin
          rmag_d = MAG_W'(vm_rnd);
        end
        rdir_d = zero_dly_q[ZERO_PAD-1] ? '0 : ang_rnd[ANG_W-1:ANG_W-DIR_W];
      end
      KIND_DOT: begin
        rdot_d = dot_dly_q[DOT_PAD-1];
        rov_d  = dov_dly_q[DOT_PAD-1];
      end
      KIND_MUL: begin
        rmag_d = side_f.mag;
        rov_d  = side_f.ov;
        rdir_d = side_f.dir;
      end
      KIND_DIV: begin
        rmag_d = div_f.mag;
        rov_d  = div_f.ov;
        rdz_d  = div_f.dz;
        rdir_d = side_f.dir;
      end
      default: begin
        rmag_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rmag_q <= rmag_d;
      rdir_q <= rdir_d;
      rdot_q <= rdot_d;
      rov_q  <= rov_d;
      rdz_q  <= rdz_d;
    end
  end

  assign rsp_o.valid            = vld_q[LAT-1];
  assign rsp_o.result_magnitude = rmag_q;
  assign rsp_o.result_direction = rdir_q;
  assign rsp_o.dot_value        = rdot_q;
  assign rsp_o.overflow         = rov_q;
  assign rsp_o.divide_by_zero   = rdz_q;

  // A zero divisor either saturates the magnitude or leaves it at zero.
  `PVA_ASSERT_IMPL(a_dz_sat, rsp_o.valid && rsp_o.divide_by_zero,
                   rsp_o.overflow || (rsp_o.result_magnitude == '0),
                   "divide by zero without saturation")

  // A dot product result carries no vector part.
  `PVA_ASSERT_IMPL(a_dot_only, rsp_o.valid && (rsp_o.dot_value != '0),
                   (rsp_o.result_magnitude == '0) && (rsp_o.result_direction == '0),
                   "dot value together with a vector result")

  // A waiting result freezes the intake.
  `PVA_ASSERT(a_stall_hold, !(rsp_o.valid && !rsp_o.ready && req_i.ready),
              "request taken while the pipeline is stalled")

endmodule
